>>> hdl/pdd_pkg.sv
`timescale 1ns / 1ps
package pdd_pkg;

	// Default ring size
	localparam int PDD_DEPTH = 64;

	// Entries in the queue between front and back
	localparam int PDD_QDEPTH = 4;

	// Field widths fixed by the stream format
	localparam int LEN_W   = 16;
	localparam int IDX_W   = 6;
	localparam int TIME_W  = 32;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd0;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
	localparam logic [OP_W-1:0] OP_PEEK       = 2'd3;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	// Slot access kinds handed to the back part
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Classified operation, everything but the slot address
	typedef struct packed {
		logic [1:0]        kind;
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  slot;
		logic [LEN_W-1:0]  len;
		logic              flag;
		logic [IDX_W-1:0]  held;
		logic [TIME_W-1:0] first_ms;
	} pdd_cmd_t;

endpackage

>>> hdl/pdd_front.sv
`timescale 1ns / 1ps
module pdd_front import pdd_pkg::*; #(
	parameter int DEPTH = PDD_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [OP_W-1:0]         operation,
	input  logic [LEN_W-1:0]        pkt_len,
	input  logic                    radio_header,
	input  logic [IDX_W-1:0]        peek_index,
	input  logic [TIME_W-1:0]       now_ms,
	output logic                    cmd_valid,
	input  logic                    cmd_ready,
	output pdd_cmd_t                cmd,
	output logic [$clog2(DEPTH)-1:0] cmd_addr
);

	localparam int PW = $clog2(DEPTH);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	logic [PW-1:0]     head_q, tail_q, count_q;
	logic [TIME_W-1:0] first_q;
	logic [PW-1:0]     head_d, tail_d, count_d;
	logic [TIME_W-1:0] first_d;
	logic              full, empty, accept;
	logic [PW-1:0]     idx_mod;
	logic [PW:0]       peek_sum;
	logic [PW-1:0]     peek_slot;
	logic [PW-1:0]     idx_mod_tbl [64];

	// Offset reduced modulo the ring size, constant table
	for (genvar i = 0; i < 64; i++) begin : g_idx_mod
		assign idx_mod_tbl[i] = PW'(i % DEPTH);
	end

	assign idx_mod   = idx_mod_tbl[peek_index];
	assign peek_sum  = {1'b0, head_q} + {1'b0, idx_mod};
	assign peek_slot = (peek_sum >= (PW + 1)'(DEPTH)) ?
		PW'(peek_sum - (PW + 1)'(DEPTH)) : peek_sum[PW-1:0];

	assign full      = (count_q == LAST);
	assign empty     = (count_q == '0);
	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;
	assign accept    = in_valid && cmd_ready;

	// Classify the beat and work out the next pointers
	always_comb begin
		head_d       = head_q;
		tail_d       = tail_q;
		count_d      = count_q;
		first_d      = first_q;
		cmd_addr     = '0;
		cmd.kind     = CMD_NONE;
		cmd.status   = ST_OK;
		cmd.len      = '0;
		cmd.flag     = 1'b0;
		unique case (operation)
			OP_PUSH_BACK: begin
				if (full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.kind = CMD_WRITE;
					cmd.len  = pkt_len;
					cmd.flag = radio_header;
					cmd_addr = tail_q;
					tail_d   = (tail_q == LAST) ? '0 : tail_q + PW'(1);
					count_d  = count_q + PW'(1);
					if (empty) first_d = now_ms;
				end
			end
			OP_PUSH_FRONT: begin
				if (full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.kind = CMD_WRITE;
					cmd.len  = pkt_len;
					count_d  = count_q + PW'(1);
					if (empty) begin
						head_d  = '0;
						tail_d  = PW'(1);
						first_d = now_ms;
					end else begin
						head_d = (head_q == '0) ? LAST : head_q - PW'(1);
					end
					cmd_addr = head_d;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					cmd.status = ST_EMPTY;
				end else begin
					cmd.kind = CMD_READ;
					cmd_addr = head_q;
					head_d   = (head_q == LAST) ? '0 : head_q + PW'(1);
					count_d  = count_q - PW'(1);
					if (count_q == PW'(1)) first_d = '1;
				end
			end
			OP_PEEK: begin
				if (empty) begin
					cmd.status = ST_EMPTY;
				end else begin
					cmd.kind = CMD_READ;
					cmd_addr = peek_slot;
				end
			end
			default: ;
		endcase
		cmd.slot     = (cmd.kind == CMD_NONE) ? '0 : IDX_W'(cmd_addr);
		cmd.held     = IDX_W'(count_d);
		cmd.first_ms = first_d;
	end

	// Advance the ring state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			first_q <= '1;
		end else if (accept) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			first_q <= first_d;
		end
	end

endmodule

>>> hdl/pdd_cmd_fifo.sv
`timescale 1ns / 1ps
module pdd_cmd_fifo import pdd_pkg::*; #(
	parameter int WIDTH  = 8,
	parameter int QDEPTH = PDD_QDEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	logic [WIDTH-1:0] entry_q [QDEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    fill_q;
	logic             do_wr, do_rd;

	assign wr_ready = (fill_q != CW'(QDEPTH));
	assign rd_valid = (fill_q != '0);
	assign rd_data  = entry_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	// Store incoming commands
	always_ff @(posedge clk) begin
		if (do_wr) entry_q[wr_ptr_q] <= wr_data;
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= (wr_ptr_q == AW'(QDEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (do_rd) rd_ptr_q <= (rd_ptr_q == AW'(QDEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (do_wr && !do_rd)      fill_q <= fill_q + CW'(1);
			else if (do_rd && !do_wr) fill_q <= fill_q - CW'(1);
		end
	end

endmodule

>>> hdl/pdd_back.sv
`timescale 1ns / 1ps
module pdd_back import pdd_pkg::*; #(
	parameter int DEPTH = PDD_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_ready,
	input  pdd_cmd_t                 cmd,
	input  logic [$clog2(DEPTH)-1:0] cmd_addr,
	output logic                     out_valid,
	input  logic                     out_ready,
	output pdd_cmd_t                 out_res
);

	logic [LEN_W-1:0] len_mem [DEPTH];
	logic             flag_mem [DEPTH];

	logic             v_s1;
	pdd_cmd_t         cmd_s1;
	logic [LEN_W-1:0] rd_len_s1;
	logic             rd_flag_s1;
	logic             out_valid_q;
	pdd_cmd_t         res_q;
	pdd_cmd_t         res_d;
	logic             take, adv;

	assign adv       = v_s1 && (!out_valid_q || out_ready);
	assign take      = cmd_valid && (!v_s1 || adv);
	assign cmd_ready = !v_s1 || adv;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	// Slot store: write on push, registered read for pop and peek
	always_ff @(posedge clk) begin
		if (take) begin
			if (cmd.kind == CMD_WRITE) begin
				len_mem[cmd_addr]  <= cmd.len;
				flag_mem[cmd_addr] <= cmd.flag;
			end
			rd_len_s1  <= len_mem[cmd_addr];
			rd_flag_s1 <= flag_mem[cmd_addr];
		end
	end

	// Hold the command beside its read data
	always_ff @(posedge clk) begin
		if (take) cmd_s1 <= cmd;
	end

	// Merge read data into the result
	always_comb begin
		res_d = cmd_s1;
		if (cmd_s1.kind == CMD_READ) begin
			res_d.len  = rd_len_s1;
			res_d.flag = rd_flag_s1;
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (adv) res_q <= res_d;
	end

	// Valid flags for the access stage and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take)     v_s1 <= 1'b1;
			else if (adv) v_s1 <= 1'b0;
			if (adv)            out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

>>> hdl/packet_descriptor_deque.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake             tuser             tdata
// s_axis    in         s_tvalid / s_tready   operation         length, flag, offset, time
// m_axis    out        m_tvalid / m_tready   status            slot, length, flag, held, time
//
// One beat per cycle sustained while m_tready stays high; a result shows on m_tvalid
// once its beat has passed the command queue, the slot store read and the output register.
// Reset clears head, tail and the count and sets the first-packet time to all
// ones; slot contents are not cleared.
// A four-entry command queue lets the input keep taking beats for a while
// when m_tready is low; s_tready drops once that queue fills.
module packet_descriptor_deque import pdd_pkg::*; #(
	parameter int DEPTH = PDD_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,  // [1:0] operation
	input  logic [55:0] s_tdata,  // [15:0] pkt_len, [16] radio_header,
	                              // [22:17] peek_index, [54:23] now_ms
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  m_tuser,  // [1:0] status
	output logic [63:0] m_tdata   // [5:0] slot, [21:6] pkt_len_res,
	                              // [22] radio_header_res, [28:23] packets_held,
	                              // [60:29] first_packet_ms
);

	localparam int PW = $clog2(DEPTH);
	localparam int QW = $bits(pdd_cmd_t) + PW;

	logic          f_valid, f_ready, b_valid, b_ready, r_valid;
	pdd_cmd_t      f_cmd, b_cmd, r_res;
	logic [PW-1:0] f_addr, b_addr;
	logic [QW-1:0] b_word;

	pdd_front #(.DEPTH(DEPTH)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.operation     (s_tuser),
		.pkt_len       (s_tdata[15:0]),
		.radio_header  (s_tdata[16]),
		.peek_index    (s_tdata[22:17]),
		.now_ms        (s_tdata[54:23]),
		.cmd_valid     (f_valid),
		.cmd_ready     (f_ready),
		.cmd           (f_cmd),
		.cmd_addr      (f_addr)
	);

	pdd_cmd_fifo #(.WIDTH(QW), .QDEPTH(PDD_QDEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  ({f_cmd, f_addr}),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_word)
	);

	assign b_cmd  = b_word[QW-1:PW];
	assign b_addr = b_word[PW-1:0];

	pdd_back #(.DEPTH(DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd       (b_cmd),
		.cmd_addr  (b_addr),
		.out_valid (r_valid),
		.out_ready (m_tready),
		.out_res   (r_res)
	);

	// Pack the result beat
	assign m_tvalid = r_valid;
	assign m_tuser  = r_res.status;
	assign m_tdata  = {3'b000, r_res.first_ms, r_res.held, r_res.flag, r_res.len, r_res.slot};

endmodule

>>> hdl/pdd_checker.sv
`timescale 1ns / 1ps
module pdd_checker import pdd_pkg::*; #(
	parameter int DEPTH = PDD_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [1:0]  m_tuser,
	input logic [63:0] m_tdata
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// A refused push reports a full ring and no slot
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_FULL |->
			m_tdata[22:0] == '0 && m_tdata[28:23] == IDX_W'(DEPTH - 1))
		else $error("full refusal with wrong fields");

	// An empty ring reports no slot, no packets and no first time
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_EMPTY |->
			m_tdata[28:0] == '0 && m_tdata[60:29] == '1)
		else $error("empty result with wrong fields");

	// A pop that drains the ring clears the first time
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_OK && m_tdata[28:23] == '0 && DEPTH <= 64 |->
			m_tdata[60:29] == '1)
		else $error("drained ring keeps a first time");

endmodule

bind packet_descriptor_deque pdd_checker #(.DEPTH(DEPTH)) u_pdd_checker (.*);

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;
	import pdd_pkg::*;

	localparam int DEPTH       = PDD_DEPTH;
	localparam int HOLD_AT     = 300;   // results seen before the long receiver hold-off
	localparam int HOLD_CYCLES = 200;
	localparam int PAUSE_AT    = 800;   // beats sent before the sender waits for a full drain
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;
	localparam int MAX_PRINTS  = 20;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [LEN_W-1:0]  len;
		logic              flag;
		logic [IDX_W-1:0]  offset;
		logic [TIME_W-1:0] now;
	} deque_cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  slot;
		logic [LEN_W-1:0]  len;
		logic              flag;
		logic [IDX_W-1:0]  held;
		logic [TIME_W-1:0] first_ms;
	} deque_rsp_t;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser  = OP_PUSH_BACK;
	logic [55:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [1:0]  m_tuser;
	logic [63:0] m_tdata;

	packet_descriptor_deque dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

	// Shadow ring state
	int                q_head;
	int                q_tail;
	logic [LEN_W-1:0]  slot_len [DEPTH];
	logic              slot_flag [DEPTH];
	bit                slot_written [DEPTH];
	logic [TIME_W-1:0] first_ms;

	deque_cmd_t pending_ops [$];
	deque_rsp_t expected_rsp [$];
	deque_cmd_t cur_cmd;
	deque_rsp_t got_rsp;
	deque_rsp_t want_rsp;

	int  n_items;
	int  n_sent;
	int  n_results;
	int  n_errors;
	int  n_full;
	int  n_empty;
	int  max_held;
	int  send_gap;
	int  ready_gap;
	int  stall_left;
	int  quiet_cycles;
	int  steer_cnt;
	bit  held_once;
	bit  paused_once;
	bit  idling;

	initial begin
		q_head      = 0;
		q_tail      = 0;
		first_ms    = '1;
		n_items     = 0;
		n_sent      = 0;
		n_results   = 0;
		n_errors    = 0;
		n_full      = 0;
		n_empty     = 0;
		max_held    = 0;
		send_gap    = 0;
		ready_gap   = 0;
		stall_left  = 0;
		quiet_cycles = 0;
		held_once   = 1'b0;
		paused_once = 1'b0;
		idling      = 1'b1;
		for (int i = 0; i < DEPTH; i++) begin
			slot_written[i] = 1'b0;
			slot_len[i]     = '0;
			slot_flag[i]    = 1'b0;
		end
	end

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int ring_count();
		return (q_tail - q_head + DEPTH) % DEPTH;
	endfunction

	// Apply one operation to the shadow ring and return the result it must produce
	function automatic deque_rsp_t deque_outcome(input deque_cmd_t c);
		deque_rsp_t r;
		int         cnt;
		int         pos;
		logic       flag;
		r        = '0;
		r.status = ST_OK;
		cnt      = ring_count();
		flag     = c.flag;
		if (c.op == OP_PUSH_BACK || c.op == OP_PUSH_FRONT) begin
			if (cnt >= DEPTH - 1) begin
				r.status = ST_FULL;
				n_full++;
			end else begin
				if (c.op == OP_PUSH_BACK) begin
					if (cnt == 0)
						first_ms = c.now;
					pos    = q_tail;
					q_tail = (q_tail + 1) % DEPTH;
				end else begin
					// front pushes never carry the radio header
					flag = 1'b0;
					if (cnt == 0) begin
						q_head   = 0;
						q_tail   = 1;
						first_ms = c.now;
					end else begin
						q_head = (q_head + DEPTH - 1) % DEPTH;
					end
					pos = q_head;
				end
				slot_len[pos]     = c.len;
				slot_flag[pos]    = flag;
				slot_written[pos] = 1'b1;
				r.slot = IDX_W'(pos);
				r.len  = c.len;
				r.flag = flag;
			end
		end else if (cnt == 0) begin
			r.status = ST_EMPTY;
			n_empty++;
		end else begin
			pos = (c.op == OP_POP_FRONT) ? q_head : (q_head + int'(c.offset)) % DEPTH;
			r.slot = IDX_W'(pos);
			r.len  = slot_len[pos];
			r.flag = slot_flag[pos];
			if (c.op == OP_POP_FRONT) begin
				q_head = (q_head + 1) % DEPTH;
				if (q_head == q_tail)
					first_ms = '1;
			end
		end
		r.held     = IDX_W'(ring_count());
		r.first_ms = first_ms;
		if (ring_count() > max_held)
			max_held = ring_count();
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		n_errors++;
		if (n_errors <= MAX_PRINTS)
			$display("mismatch on result %0d: %s got %h expected %h", n_results, what, got, want);
	endtask

	task automatic add_cmd(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] len,
	                       input logic flag, input logic [IDX_W-1:0] offset,
	                       input logic [TIME_W-1:0] now);
		deque_cmd_t c;
		c.op     = op;
		c.len    = len;
		c.flag   = flag;
		c.offset = offset;
		c.now    = now;
		pending_ops.push_back(c);
	endtask

	// Random content, with the field extremes showing up often
	task automatic add_random_cmd(input logic [OP_W-1:0] op);
		logic [LEN_W-1:0]  len;
		logic [TIME_W-1:0] now;
		case ($urandom_range(0, 5))
			0: len = '0;
			1: len = '1;
			default: len = LEN_W'($urandom_range(0, 65535));
		endcase
		case ($urandom_range(0, 7))
			0: now = '0;
			1: now = '1;
			default: now = $urandom();
		endcase
		add_cmd(op, len, 1'(($urandom_range(0, 1))), IDX_W'($urandom_range(0, 63)), now);
	endtask

	// Build the stimulus, release reset, wait for the drain and conclude
	initial begin
		traffic_mode_t mode;
		int            run;
		int            push_share;
		logic [OP_W-1:0] op;

		// directed opening: empty ring, front push restart, wrap of head, drain to empty
		add_cmd(OP_POP_FRONT,  16'h0000, 1'b0, 6'd0,  32'h0000_0000);
		add_cmd(OP_PEEK,       16'h0000, 1'b1, 6'd63, 32'hFFFF_FFFF);
		add_cmd(OP_PUSH_FRONT, 16'hFFFF, 1'b1, 6'd0,  32'h0000_0000);
		add_cmd(OP_PUSH_BACK,  16'h0000, 1'b1, 6'd63, 32'hFFFF_FFFF);
		add_cmd(OP_PUSH_FRONT, 16'h1234, 1'b1, 6'd0,  32'h5555_AAAA);
		add_cmd(OP_PEEK,       16'h0000, 1'b0, 6'd0,  32'h0000_0000);
		add_cmd(OP_PEEK,       16'h0000, 1'b0, 6'd1,  32'h0000_0000);
		add_cmd(OP_PEEK,       16'h0000, 1'b0, 6'd2,  32'h0000_0000);
		add_cmd(OP_POP_FRONT,  16'hFFFF, 1'b1, 6'd0,  32'h0000_0000);
		add_cmd(OP_POP_FRONT,  16'h0000, 1'b0, 6'd0,  32'h0000_0000);
		add_cmd(OP_POP_FRONT,  16'h0000, 1'b0, 6'd0,  32'h0000_0000);
		add_cmd(OP_POP_FRONT,  16'h0000, 1'b0, 6'd0,  32'h0000_0000);
		add_cmd(OP_PEEK,       16'h0000, 1'b0, 6'd5,  32'h0000_0000);
		add_cmd(OP_PUSH_BACK,  16'hFFFF, 1'b1, 6'd0,  32'hFFFF_FFFF);
		add_cmd(OP_PUSH_BACK,  16'h8001, 1'b0, 6'd0,  32'h0000_0000);
		add_cmd(OP_PUSH_FRONT, 16'h0000, 1'b1, 6'd0,  32'h1234_5678);
		add_cmd(OP_PEEK,       16'h0000, 1'b0, 6'd2,  32'h0000_0000);
		add_cmd(OP_POP_FRONT,  16'h0000, 1'b0, 6'd0,  32'h0000_0000);
		add_cmd(OP_POP_FRONT,  16'h0000, 1'b0, 6'd0,  32'h0000_0000);
		add_cmd(OP_POP_FRONT,  16'h0000, 1'b0, 6'd0,  32'h0000_0000);

		// fill to the limit, hit both refusals, peek the far end, drain fully
		repeat (DEPTH - 1)
			add_random_cmd(OP_PUSH_BACK);
		add_random_cmd(OP_PUSH_BACK);
		add_random_cmd(OP_PUSH_FRONT);
		add_cmd(OP_PEEK, 16'h0000, 1'b0, IDX_W'(DEPTH - 2), 32'h0000_0000);
		repeat (DEPTH)
			add_random_cmd(OP_POP_FRONT);

		// random phases biased toward filling, draining or churning
		while (pending_ops.size() < 1400) begin
			mode = traffic_mode_t'($urandom_range(0, 2));
			run  = $urandom_range(30, 140);
			case (mode)
				MODE_FILL:  push_share = 8;
				MODE_DRAIN: push_share = 2;
				default:    push_share = 5;
			endcase
			repeat (run) begin
				if ($urandom_range(0, 9) < push_share)
					op = ($urandom_range(0, 2) == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
				else
					op = ($urandom_range(0, 1) == 0) ? OP_POP_FRONT : OP_PEEK;
				add_random_cmd(op);
			end
		end
		n_items = pending_ops.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait (n_sent == n_items);
		wait (expected_rsp.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d deque operations checked, deepest fill %0d of %0d slots",
		         n_results, max_held, DEPTH - 1);
		$display("%0d pushes refused on a full ring, %0d pops or peeks on an empty one",
		         n_full, n_empty);
		if (n_errors == 0 && expected_rsp.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Sender: predict each accepted beat, then offer the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= OP_PUSH_BACK;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_rsp.push_back(deque_outcome(cur_cmd));
				n_sent++;
			end
			idling <= (n_sent + 150 < n_items) && ((n_sent / 250) % 3 != 2);
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (n_sent == PAUSE_AT && !paused_once) begin
					// hold until every outstanding result is back
					s_tvalid <= 1'b0;
					if (expected_rsp.size() == 0)
						paused_once = 1'b1;
				end else if (pending_ops.size() > 0) begin
					cur_cmd   = pending_ops.pop_front();
					steer_cnt = ring_count();
					// steer peeks away from slots that no push has written yet
					if (cur_cmd.op == OP_PEEK && steer_cnt > 0 &&
					    !slot_written[(q_head + int'(cur_cmd.offset)) % DEPTH])
						cur_cmd.offset = IDX_W'(int'(cur_cmd.offset) % steer_cnt);
					s_tvalid <= 1'b1;
					s_tuser  <= cur_cmd.op;
					s_tdata  <= {1'b0, cur_cmd.now, cur_cmd.offset, cur_cmd.flag, cur_cmd.len};
					if (idling && $urandom_range(0, 3) == 0)
						send_gap = $urandom_range(1, 3);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result beat against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results++;
				got_rsp.status   = m_tuser;
				got_rsp.slot     = m_tdata[5:0];
				got_rsp.len      = m_tdata[21:6];
				got_rsp.flag     = m_tdata[22];
				got_rsp.held     = m_tdata[28:23];
				got_rsp.first_ms = m_tdata[60:29];
				if (expected_rsp.size() == 0) begin
					report_mismatch("result with nothing pending, slot", 32'(got_rsp.slot), '0);
				end else begin
					want_rsp = expected_rsp.pop_front();
					if (got_rsp.status != want_rsp.status)
						report_mismatch("status", 32'(got_rsp.status), 32'(want_rsp.status));
					if (got_rsp.slot != want_rsp.slot)
						report_mismatch("slot", 32'(got_rsp.slot), 32'(want_rsp.slot));
					if (got_rsp.len != want_rsp.len)
						report_mismatch("length", 32'(got_rsp.len), 32'(want_rsp.len));
					if (got_rsp.flag != want_rsp.flag)
						report_mismatch("radio header", 32'(got_rsp.flag), 32'(want_rsp.flag));
					if (got_rsp.held != want_rsp.held)
						report_mismatch("held count", 32'(got_rsp.held), 32'(want_rsp.held));
					if (got_rsp.first_ms != want_rsp.first_ms)
						report_mismatch("first packet time", got_rsp.first_ms, want_rsp.first_ms);
				end
			end

			// drive ready: one long hold-off, and short random gaps while idling is set
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (n_results == HOLD_AT && !held_once) begin
				held_once  = 1'b1;
				stall_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (ready_gap > 0) begin
				ready_gap--;
				m_tready <= 1'b0;
			end else if (idling && $urandom_range(0, 7) == 0) begin
				ready_gap = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if no beat moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

endmodule

>>> packet_descriptor_deque.f
hdl/pdd_pkg.sv
hdl/pdd_front.sv
hdl/pdd_cmd_fifo.sv
hdl/pdd_back.sv
hdl/packet_descriptor_deque.sv
hdl/pdd_checker.sv
test/tb.sv
